// ----- rtl/crc8fr_pkg.sv -----
// Shared types, constants and the CRC-8 step function of the frame receiver.
package crc8fr_pkg;

    // Payload buffer depth and derived widths.
    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W       = 6;
    localparam int LIMIT_W     = 7;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int TX_TDATA_W  = 2 * BYTE_W;
    localparam int TX_TUSER_W  = 1 + STATUS_W;

    // Frame constants.
    localparam logic [BYTE_W-1:0] SYNC_A   = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_B   = 8'hBB;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 6'd32;

    // Bits of the CRC advanced by the shared unit in one cycle.
    localparam int CRC_BITS_PER_CYCLE = 4;

    // Parser phase within a frame.
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_SEQ   = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } t_phase;

    // Sequencer state.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_EMIT,
        ST_RD,
        ST_LOAD
    } t_state;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_HDR = 2'd1,
        STAT_LEN     = 2'd2,
        STAT_BAD_CRC = 2'd3
    } t_status;

    // Advances the CRC register by four message bits, MSB first.
    function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] c_in);
        logic [BYTE_W-1:0] c;
        c = c_in;
        for (int k = 0; k < CRC_BITS_PER_CYCLE; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/crc8_frame_receiver.sv -----
// CRC-8 framed packet receiver: header parse, CRC check, payload buffer and drain.
// Sequence, valid length and payload bytes pass ST_CRC: the shared CRC unit does 4 bits per cycle.
// Sync bytes need only ST_IDLE; a byte with an error or empty-frame result adds ST_EMIT to load it.
// A good check byte drains the payload RAM via ST_RD, ST_LOAD per byte; stalls hold ST_LOAD.
// Synchronous active-low reset: parser hunts for 0xAA, max_len = 32, output empty.
// The payload RAM is not cleared; entries are only read after being written.
module crc8_frame_receiver (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [crc8fr_pkg::LEN_W-1:0]       i_cfg_wdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [crc8fr_pkg::BYTE_W-1:0]      i_s_axis_tdata,  // [7:0] rx_byte
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [crc8fr_pkg::TX_TDATA_W-1:0]  o_m_axis_tdata,  // [7:0] data_byte, [15:8] ack_seq
    output logic [crc8fr_pkg::TX_TUSER_W-1:0]  o_m_axis_tuser,  // [0] data_valid, [2:1] status
    output logic                               o_m_axis_tlast
);
    import crc8fr_pkg::*;

    // Control and frame state.
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [LEN_W-1:0]    r_max_len;
    logic [BYTE_W-1:0]   r_seq;
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    r_cnt;
    logic [BYTE_W-1:0]   r_crc;
    t_status             r_res_status;
    logic [ADDR_W-1:0]   r_rd_idx;

    // Output register.
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_data;
    logic                r_out_dvalid;
    logic                r_out_last;
    t_status             r_out_status;
    logic [BYTE_W-1:0]   r_out_seq;

    // Decode and datapath signals.
    logic                w_accept;
    logic [BYTE_W-1:0]   w_rx;
    logic [LIMIT_W-1:0]  w_limit;
    logic                w_crc_op;
    logic [BYTE_W-1:0]   w_crc_seed;
    logic [BYTE_W-1:0]   w_crc_in;
    logic [BYTE_W-1:0]   w_crc_out;
    logic                w_single;
    t_status             w_single_status;
    logic                w_drain;
    logic                w_wr_en;
    logic                w_seq_ld;
    logic                w_len_ld;
    logic                w_cnt_inc;
    logic                w_out_free;
    logic                w_ld_emit;
    logic                w_ld_drain;
    logic                w_rd_last;
    logic [BYTE_W-1:0]   w_rd_data;

    assign w_rx       = i_s_axis_tdata;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_rd_last  = (LEN_W'(r_rd_idx) + LEN_W'(1)) == r_len;

    // Effective length limit: the smaller of max_len and the buffer depth.
    always_comb begin
        if (LIMIT_W'(r_max_len) > LIMIT_W'(MAX_PAYLOAD)) begin
            w_limit = LIMIT_W'(MAX_PAYLOAD);
        end else begin
            w_limit = LIMIT_W'(r_max_len);
        end
    end

    // Frame parser: what the current byte does in the current phase.
    always_comb begin
        n_phase         = r_phase;
        w_crc_op        = 1'b0;
        w_crc_seed      = r_crc;
        w_single        = 1'b0;
        w_single_status = STAT_OK;
        w_drain         = 1'b0;
        w_wr_en         = 1'b0;
        w_seq_ld        = 1'b0;
        w_len_ld        = 1'b0;
        w_cnt_inc       = 1'b0;
        unique case (r_phase)
            PH_SYNC2: begin
                if (w_rx != SYNC_B) begin
                    w_single        = 1'b1;
                    w_single_status = STAT_BAD_HDR;
                    n_phase         = PH_HUNT;
                end else begin
                    n_phase = PH_SEQ;
                end
            end
            PH_SEQ: begin
                w_seq_ld   = 1'b1;
                w_crc_op   = 1'b1;
                w_crc_seed = CRC_INIT;
                n_phase    = PH_LEN;
            end
            PH_LEN: begin
                if (w_rx > BYTE_W'(w_limit)) begin
                    w_single        = 1'b1;
                    w_single_status = STAT_LEN;
                    n_phase         = PH_HUNT;
                end else begin
                    w_crc_op = 1'b1;
                    w_len_ld = 1'b1;
                    n_phase  = (w_rx[LEN_W-1:0] == '0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA: begin
                w_wr_en   = 1'b1;
                w_crc_op  = 1'b1;
                w_cnt_inc = 1'b1;
                if ((r_cnt + LEN_W'(1)) >= r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase = PH_HUNT;
                if (w_rx != r_crc) begin
                    w_single        = 1'b1;
                    w_single_status = STAT_BAD_CRC;
                end else if (r_len == '0) begin
                    w_single = 1'b1;
                end else begin
                    w_drain = 1'b1;
                end
            end
            default: begin
                if (w_rx != SYNC_A) begin
                    w_single        = 1'b1;
                    w_single_status = STAT_BAD_HDR;
                    n_phase         = PH_HUNT;
                end else begin
                    n_phase = PH_SYNC2;
                end
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_crc_op) begin
                        n_state = ST_CRC;
                    end else if (w_single) begin
                        n_state = ST_EMIT;
                    end else if (w_drain) begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_CRC: begin
                n_state = ST_IDLE;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (w_out_free) begin
                    n_state = w_rd_last ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake, shared CRC unit operand and output loads.
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_crc_in        = r_crc;
        w_ld_emit       = 1'b0;
        w_ld_drain      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_crc_in        = w_crc_seed ^ w_rx;
            end
            ST_CRC: begin
                w_crc_in = r_crc;
            end
            ST_EMIT: begin
                w_ld_emit = w_out_free;
            end
            ST_RD: begin
                w_crc_in = r_crc;
            end
            ST_LOAD: begin
                w_ld_drain = w_out_free;
            end
            default: begin
                w_crc_in = r_crc;
            end
        endcase
    end

    // Shared CRC unit: four bit steps per cycle.
    assign w_crc_out = crc_step(w_crc_in);

    // Payload buffer.
    crc8fr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && w_wr_en),
        .i_wr_addr (r_cnt[ADDR_W-1:0]),
        .i_wr_data (w_rx),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_rd_data)
    );

    // Control and frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_HUNT;
            r_max_len    <= MAX_LEN_RESET;
            r_seq        <= '0;
            r_len        <= '0;
            r_cnt        <= '0;
            r_crc        <= CRC_INIT;
            r_res_status <= STAT_OK;
            r_rd_idx     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_phase <= n_phase;
                if (w_seq_ld) begin
                    r_seq <= w_rx;
                end
                if (w_len_ld) begin
                    r_len <= w_rx[LEN_W-1:0];
                    r_cnt <= '0;
                end
                if (w_cnt_inc) begin
                    r_cnt <= r_cnt + LEN_W'(1);
                end
                if (w_crc_op) begin
                    r_crc <= w_crc_out;
                end
                if (w_single) begin
                    r_res_status <= w_single_status;
                end
                if (w_drain) begin
                    r_rd_idx <= '0;
                end
            end
            if (r_state == ST_CRC) begin
                r_crc <= w_crc_out;
            end
            if (w_ld_drain) begin
                r_rd_idx <= r_rd_idx + ADDR_W'(1);
            end
            if (w_ld_emit || w_ld_drain) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_ld_emit) begin
            r_out_data   <= '0;
            r_out_dvalid <= 1'b0;
            r_out_last   <= 1'b1;
            r_out_status <= r_res_status;
            r_out_seq    <= (r_res_status == STAT_OK) ? r_seq : '0;
        end else if (w_ld_drain) begin
            r_out_data   <= w_rd_data;
            r_out_dvalid <= 1'b1;
            r_out_last   <= w_rd_last;
            r_out_status <= STAT_OK;
            r_out_seq    <= r_seq;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_seq, r_out_data};
    assign o_m_axis_tuser  = {r_out_status, r_out_dvalid};
    assign o_m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    // A byte that updates the CRC is always followed by the ST_CRC state.
    a_crc_second_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_crc_op) |=> (r_state == ST_CRC))
        else $error("CRC byte did not enter its second cycle");

    // The payload count stays below the frame length while collecting payload.
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_cnt < r_len))
        else $error("payload count reached frame length in payload phase");

    // The drain never reads past the frame length.
    a_drain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RD) || (r_state == ST_LOAD)) |-> (LEN_W'(r_rd_idx) < r_len))
        else $error("drain index beyond frame length");

    // A payload byte is only ever shown with ok status.
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dvalid) |-> (r_out_status == STAT_OK))
        else $error("payload byte with error status");

    // Error results are single, last, and carry no sequence number.
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != STAT_OK)) |-> (r_out_last && (r_out_seq == '0)))
        else $error("malformed error result");
`endif

endmodule

// ----- rtl/crc8fr_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module crc8fr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
